/* rtl/ptpc_pkg.sv */
// Shared types and constants for the planar tile pixel codec.
// No dependencies.
package ptpc_pkg;

   localparam logic [2:0] FUNC_WR_ROM  = 3'd0;
   localparam logic [2:0] FUNC_RD_ROM  = 3'd1;
   localparam logic [2:0] FUNC_WR_LAY  = 3'd2;
   localparam logic [2:0] FUNC_DECODE  = 3'd3;
   localparam logic [2:0] FUNC_ENCODE  = 3'd4;

   localparam logic [1:0] TSEL_X = 2'd0;
   localparam logic [1:0] TSEL_Y = 2'd1;
   localparam logic [1:0] TSEL_P = 2'd2;

   localparam logic [2:0] CSR_START  = 3'd0;
   localparam logic [2:0] CSR_CHARINC = 3'd1;
   localparam logic [2:0] CSR_PLANES = 3'd2;
   localparam logic [2:0] CSR_WIDTH  = 3'd3;
   localparam logic [2:0] CSR_HEIGHT = 3'd4;
   localparam logic [2:0] CSR_ORIENT = 3'd5;
   localparam logic [2:0] CSR_CBASE  = 3'd6;

   localparam logic [2:0] ORI_FLIPX = 3'd1;
   localparam logic [2:0] ORI_FLIPY = 3'd2;
   localparam logic [2:0] ORI_ROT180 = 3'd3;
   localparam logic [2:0] ORI_ROT90 = 3'd4;
   localparam logic [2:0] ORI_ROT270 = 3'd5;

   localparam logic [7:0] MSB_MASK = 8'h80;

   // classified operation handed from front to back
   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_WR   = 3'd1,
      OP_RD   = 3'd2,
      OP_DEC  = 3'd3,
      OP_ENC  = 3'd4,
      OP_POFF = 3'd5
   } op_type;

endpackage

/* rtl/ptpc_front.sv */
// Front end: accepts items, updates layout tables, computes base bit
// address and destination coordinates. Uses ptpc_pkg.
module ptpc_front #(
   parameter int MAX_DIM    = 32,
   parameter int MAX_PLANES = 8,
   parameter int BA_W       = 19
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_func,
   input  logic [15:0]         req_address,
   input  logic [1:0]          req_table_select,
   input  logic [18:0]         req_data,
   input  logic [11:0]         req_sprite_index,
   input  logic [4:0]          req_src_x,
   input  logic [4:0]          req_src_y,
   input  logic [7:0]          req_pixel_value,
   input  logic [15:0]         start_address,
   input  logic [18:0]         char_increment,
   input  logic [5:0]          sprite_width,
   input  logic [5:0]          sprite_height,
   input  logic [2:0]          orientation,
   input  logic [7:0]          color_base,
   // queue write side
   input  logic                q_full,
   output logic                q_push,
   output ptpc_pkg::op_type    q_op,
   output logic [BA_W-1:0]     q_base,
   output logic [18:0]         q_ldat,
   output logic [15:0]         q_addr,
   output logic [7:0]          q_val,
   output logic [4:0]          q_dx,
   output logic [4:0]          q_dy
);
   localparam int XW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   logic [18:0] xoff_ff [MAX_DIM];
   logic [18:0] yoff_ff [MAX_DIM];

   // stage 1 registers (multiply product)
   logic                 s1_vld_ff, s1_vld_in;
   ptpc_pkg::op_type     s1_op_ff;
   logic [BA_W-1:0]      s1_prod_ff;
   logic [18:0]          s1_xo_ff, s1_yo_ff;
   logic [18:0]          s1_ldat_ff;
   logic [15:0]          s1_addr_ff;
   logic [7:0]           s1_val_ff;
   logic [4:0]           s1_dx_ff, s1_dy_ff;

   logic accept;
   assign req_stall = s1_vld_ff && q_full;
   assign accept = req_valid && !req_stall;

   ptpc_pkg::op_type op_c;
   always_comb begin
      unique case (req_func)
         ptpc_pkg::FUNC_WR_ROM: op_c = ptpc_pkg::OP_WR;
         ptpc_pkg::FUNC_RD_ROM: op_c = ptpc_pkg::OP_RD;
         // plane offsets live in the back end; send them down in order
         ptpc_pkg::FUNC_WR_LAY:
            op_c = (req_table_select == ptpc_pkg::TSEL_P && 32'(req_address) < MAX_PLANES)
                   ? ptpc_pkg::OP_POFF : ptpc_pkg::OP_NONE;
         ptpc_pkg::FUNC_DECODE: op_c = ptpc_pkg::OP_DEC;
         ptpc_pkg::FUNC_ENCODE: op_c = ptpc_pkg::OP_ENC;
         default:               op_c = ptpc_pkg::OP_NONE;
      endcase
   end

   logic [5:0] rx, ry, dx_c, dy_c;
   always_comb begin
      rx = sprite_width - 6'd1 - {1'b0, req_src_x};
      ry = sprite_height - 6'd1 - {1'b0, req_src_y};
      unique case (orientation)
         ptpc_pkg::ORI_FLIPX:  begin dx_c = rx; dy_c = {1'b0, req_src_y}; end
         ptpc_pkg::ORI_FLIPY:  begin dx_c = {1'b0, req_src_x}; dy_c = ry; end
         ptpc_pkg::ORI_ROT180: begin dx_c = rx; dy_c = ry; end
         ptpc_pkg::ORI_ROT90:  begin dx_c = ry; dy_c = {1'b0, req_src_x}; end
         ptpc_pkg::ORI_ROT270: begin dx_c = {1'b0, req_src_y}; dy_c = rx; end
         default:              begin dx_c = {1'b0, req_src_x}; dy_c = {1'b0, req_src_y}; end
      endcase
   end

   logic [30:0] prod_c;
   assign prod_c = req_sprite_index * char_increment;

   logic is_code;
   assign is_code = (op_c == ptpc_pkg::OP_DEC) || (op_c == ptpc_pkg::OP_ENC);

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (s1_vld_ff && !q_full) s1_vld_in = 1'b0;
      if (accept) s1_vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= op_c;
         s1_prod_ff <= BA_W'(prod_c);
         s1_xo_ff   <= xoff_ff[XW'(req_src_x)];
         s1_yo_ff   <= yoff_ff[XW'(req_src_y)];
         s1_ldat_ff <= req_data;
         s1_addr_ff <= req_address;
         s1_val_ff  <= (op_c == ptpc_pkg::OP_ENC) ? (req_pixel_value - color_base)
                                                  : req_data[7:0];
         s1_dx_ff   <= is_code ? dx_c[4:0] : 5'd0;
         s1_dy_ff   <= is_code ? dy_c[4:0] : 5'd0;
         if (req_func == ptpc_pkg::FUNC_WR_LAY) begin
            if (req_table_select == ptpc_pkg::TSEL_X && 32'(req_address) < MAX_DIM)
               xoff_ff[req_address[XW-1:0]] <= req_data;
            if (req_table_select == ptpc_pkg::TSEL_Y && 32'(req_address) < MAX_DIM)
               yoff_ff[req_address[XW-1:0]] <= req_data;
         end
      end
   end

   assign q_push = s1_vld_ff && !q_full;
   assign q_op   = s1_op_ff;
   assign q_base = BA_W'({start_address, 3'b000}) + s1_prod_ff
                   + BA_W'(s1_xo_ff) + BA_W'(s1_yo_ff);
   assign q_ldat = s1_ldat_ff;
   assign q_addr = s1_addr_ff;
   assign q_val  = s1_val_ff;
   assign q_dx   = s1_dx_ff;
   assign q_dy   = s1_dy_ff;
endmodule

/* rtl/ptpc_queue.sv */
// Two-entry queue between front and back ends.
// Carries the classified operation as a flat word; no dependencies.
module ptpc_queue #(
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] wdata,
   output logic          full,
   input  logic          pop,
   output logic          empty,
   output logic [DW-1:0] rdata
);
   logic [DW-1:0] mem_ff [2];
   logic          wp_ff, rp_ff;
   logic [1:0]    cnt_ff;

   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= wdata;
   end
endmodule

/* rtl/ptpc_back.sv */
// Back end: ROM array and plane offset table; runs plane bit reads and
// read-modify-writes one access at a time. Uses ptpc_pkg.
module ptpc_back #(
   parameter int ROM_BYTES  = 65536,
   parameter int MAX_PLANES = 8,
   parameter int BA_W       = 19
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   output logic                q_pop,
   input  ptpc_pkg::op_type    q_op,
   input  logic [BA_W-1:0]     q_base,
   input  logic [18:0]         q_ldat,
   input  logic [15:0]         q_addr,
   input  logic [7:0]          q_val,
   input  logic [4:0]          q_dx,
   input  logic [4:0]          q_dy,
   input  logic [3:0]          plane_count,
   input  logic [7:0]          color_base,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_read_data,
   output logic [7:0]          rsp_color,
   output logic [4:0]          rsp_dest_x,
   output logic [4:0]          rsp_dest_y
);
   localparam int AW = $clog2(ROM_BYTES);
   localparam int PW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
   localparam int FULLW = AW + 3;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ADDR = 5'b00010,
      ST_READ = 5'b00100,
      ST_MOD  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   logic [7:0]  rom [ROM_BYTES];
   logic [18:0] poff_ff [MAX_PLANES];

   state_type        st_ff, st_in;
   ptpc_pkg::op_type op_ff;
   logic [BA_W-1:0]  base_ff;
   logic [7:0]       val_ff, acc_ff, rd_ff;
   logic [4:0]       dx_ff, dy_ff;
   logic [3:0]       p_ff, np_ff;
   logic [FULLW-1:0] ba_ff;
   logic [7:0]       rdat_ff;
   logic             rsp_vld_ff;
   logic [7:0]       r_rd_ff, r_col_ff;
   logic [4:0]       r_dx_ff, r_dy_ff;

   always_ff @(posedge clock) begin
      if (q_pop && q_op == ptpc_pkg::OP_POFF) poff_ff[q_addr[PW-1:0]] <= q_ldat;
   end

   logic [3:0] planes_c;
   assign planes_c = (32'(plane_count) > MAX_PLANES) ? 4'(MAX_PLANES) : plane_count;

   logic [FULLW+1:0] ba_sum;
   assign ba_sum = (FULLW+2)'(base_ff) + (FULLW+2)'(poff_ff[p_ff[PW-1:0]]);

   logic [7:0] mask_c;
   assign mask_c = ptpc_pkg::MSB_MASK >> ba_ff[2:0];
   logic [3:0] shamt;
   assign shamt = np_ff - 4'd1 - p_ff;
   logic bit_c;
   assign bit_c = val_ff[shamt[2:0]];

   logic out_free;
   assign out_free = !rsp_vld_ff || !rsp_stall;
   assign q_pop = (st_ff == ST_IDLE) && !q_empty;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (!q_empty) begin
            if ((q_op == ptpc_pkg::OP_DEC || q_op == ptpc_pkg::OP_ENC)
                && planes_c != 4'd0)
               st_in = ST_ADDR;
            else if (q_op == ptpc_pkg::OP_RD)
               st_in = ST_READ;
            else
               st_in = ST_OUT;
         end
         ST_ADDR: st_in = ST_READ;
         ST_READ: st_in = (op_ff == ptpc_pkg::OP_RD) ? ST_OUT : ST_MOD;
         ST_MOD:  st_in = (p_ff + 4'd1 == np_ff) ? ST_OUT : ST_ADDR;
         ST_OUT:  if (out_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) st_ff <= ST_IDLE;
      else       st_ff <= st_in;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_vld_ff <= 1'b0;
      else if (st_ff == ST_OUT && out_free) rsp_vld_ff <= 1'b1;
      else if (!rsp_stall) rsp_vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      unique case (st_ff)
         ST_IDLE: begin
            op_ff <= q_op; base_ff <= q_base;
            val_ff <= q_val; dx_ff <= q_dx; dy_ff <= q_dy;
            p_ff <= 4'd0; np_ff <= planes_c; acc_ff <= 8'd0; rd_ff <= 8'd0;
            ba_ff <= FULLW'({q_addr, 3'b000});
            if (!q_empty && q_op == ptpc_pkg::OP_WR)
               rom[AW'(q_addr)] <= q_val;
         end
         ST_ADDR: ba_ff <= ba_sum[FULLW-1:0];
         ST_READ: begin
            rdat_ff <= rom[ba_ff[FULLW-1:3]];
            if (op_ff == ptpc_pkg::OP_RD) rd_ff <= rom[ba_ff[FULLW-1:3]];
         end
         ST_MOD: begin
            p_ff <= p_ff + 4'd1;
            if (op_ff == ptpc_pkg::OP_DEC)
               acc_ff <= {acc_ff[6:0], (rdat_ff & mask_c) != 8'd0};
            else
               rom[ba_ff[FULLW-1:3]] <= bit_c ? (rdat_ff | mask_c) : (rdat_ff & ~mask_c);
         end
         ST_OUT: if (out_free) begin
            r_rd_ff  <= rd_ff;
            r_col_ff <= (op_ff == ptpc_pkg::OP_DEC) ? color_base + acc_ff : 8'd0;
            r_dx_ff  <= dx_ff;
            r_dy_ff  <= dy_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_read_data = r_rd_ff;
   assign rsp_color     = r_col_ff;
   assign rsp_dest_x    = r_dx_ff;
   assign rsp_dest_y    = r_dy_ff;
endmodule

/* rtl/planar_tile_pixel_codec.sv */
// Planar tile pixel codec: a front end computes the tile bit address with one
// multiply and the orientation transform, a two-entry queue decouples it from a
// back end that owns the ROM and the plane offset table. An accepted transfer
// passes the front end's stage register and the queue to the back end, which
// registers its result. For a decode or encode the back end walks the planes
// in turn on its single ROM port, each through an address add, a byte read and
// a bit update. It takes no new item from the queue until the last one's result
// is in its output register. ROM and layout tables are undefined until written.
module planar_tile_pixel_codec #(
   parameter int ROM_BYTES  = 65536,
   parameter int MAX_DIM    = 32,
   parameter int MAX_PLANES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [18:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [15:0] req_address,
   input  logic [1:0]  req_table_select,
   input  logic [18:0] req_data,
   input  logic [11:0] req_sprite_index,
   input  logic [4:0]  req_src_x,
   input  logic [4:0]  req_src_y,
   input  logic [7:0]  req_pixel_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_read_data,
   output logic [7:0]  rsp_color,
   output logic [4:0]  rsp_dest_x,
   output logic [4:0]  rsp_dest_y
);
   localparam int BA_W = $clog2(ROM_BYTES) + 3;
   localparam int QW = 3 + BA_W + 19 + 16 + 8 + 5 + 5;

   logic [15:0] start_ff;
   logic [18:0] cinc_ff;
   logic [3:0]  planes_ff;
   logic [5:0]  width_ff, height_ff;
   logic [2:0]  orient_ff;
   logic [7:0]  cbase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 16'd0; cinc_ff <= 19'd0; planes_ff <= 4'd1;
         width_ff <= 6'd8; height_ff <= 6'd8; orient_ff <= 3'd0; cbase_ff <= 8'd0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            ptpc_pkg::CSR_START:   start_ff  <= csr_data[15:0];
            ptpc_pkg::CSR_CHARINC: cinc_ff   <= csr_data;
            ptpc_pkg::CSR_PLANES:  planes_ff <= csr_data[3:0];
            ptpc_pkg::CSR_WIDTH:   width_ff  <= csr_data[5:0];
            ptpc_pkg::CSR_HEIGHT:  height_ff <= csr_data[5:0];
            ptpc_pkg::CSR_ORIENT:  orient_ff <= csr_data[2:0];
            ptpc_pkg::CSR_CBASE:   cbase_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   logic             q_full, q_push, q_empty, q_pop;
   ptpc_pkg::op_type f_op, b_op;
   logic [BA_W-1:0]  f_base, b_base;
   logic [18:0]      f_ldat, b_ldat;
   logic [15:0]      f_addr, b_addr;
   logic [7:0]       f_val, b_val;
   logic [4:0]       f_dx, f_dy, b_dx, b_dy;
   logic [QW-1:0]    q_rdata;

   ptpc_front #(.MAX_DIM(MAX_DIM), .MAX_PLANES(MAX_PLANES), .BA_W(BA_W)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_func, .req_address,
      .req_table_select, .req_data, .req_sprite_index, .req_src_x, .req_src_y,
      .req_pixel_value,
      .start_address(start_ff), .char_increment(cinc_ff), .sprite_width(width_ff),
      .sprite_height(height_ff), .orientation(orient_ff), .color_base(cbase_ff),
      .q_full, .q_push, .q_op(f_op), .q_base(f_base), .q_ldat(f_ldat), .q_addr(f_addr),
      .q_val(f_val), .q_dx(f_dx), .q_dy(f_dy)
   );

   ptpc_queue #(.DW(QW)) u_queue (
      .clock, .reset, .push(q_push),
      .wdata({f_op, f_base, f_ldat, f_addr, f_val, f_dx, f_dy}),
      .full(q_full), .pop(q_pop), .empty(q_empty), .rdata(q_rdata)
   );

   assign b_op   = ptpc_pkg::op_type'(q_rdata[QW-1 -: 3]);
   assign b_base = q_rdata[QW-4 -: BA_W];
   assign b_ldat = q_rdata[52:34];
   assign b_addr = q_rdata[33:18];
   assign b_val  = q_rdata[17:10];
   assign b_dx   = q_rdata[9:5];
   assign b_dy   = q_rdata[4:0];

   ptpc_back #(.ROM_BYTES(ROM_BYTES), .MAX_PLANES(MAX_PLANES), .BA_W(BA_W)) u_back (
      .clock, .reset, .q_empty, .q_pop, .q_op(b_op), .q_base(b_base), .q_ldat(b_ldat),
      .q_addr(b_addr), .q_val(b_val), .q_dx(b_dx), .q_dy(b_dy),
      .plane_count(planes_ff), .color_base(cbase_ff),
      .rsp_valid, .rsp_stall, .rsp_read_data, .rsp_color, .rsp_dest_x, .rsp_dest_y
   );
endmodule

/* test/testbench.sv */
// Self-checking testbench for planar_tile_pixel_codec: random and directed ROM, layout,
// decode and encode transfers, checked against an in-bench prediction of the codec.
// Depends on rtl/ptpc_pkg.sv and rtl/planar_tile_pixel_codec.sv.
module testbench;

   localparam int CYCLE_LIMIT = 900000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 308;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] address;
      logic [1:0]  tsel;
      logic [18:0] data;
      logic [11:0] sprite;
      logic [4:0]  sx;
      logic [4:0]  sy;
      logic [7:0]  pixel;
   } request_type;

   typedef struct packed {
      logic [7:0] rd;
      logic [7:0] color;
      logic [4:0] dx;
      logic [4:0] dy;
   } response_type;

   // Tracks ROM, layout tables and registers; predicts and checks pixel results.
   class pixel_codec_tracker;
      logic [7:0]   rom [65536];
      bit           rom_set [65536];
      logic [18:0]  xoff [32];
      logic [18:0]  yoff [32];
      logic [18:0]  poff [8];
      bit           xset [32];
      bit           yset [32];
      bit           pset [8];
      logic [15:0]  start_addr;
      logic [18:0]  char_inc;
      logic [3:0]   plane_cnt;
      logic [5:0]   width;
      logic [5:0]   height;
      logic [2:0]   orient;
      logic [7:0]   cbase;
      response_type pending [$];
      int           mismatches;
      int           checked;

      function new();
         start_addr = 0;
         char_inc   = 0;
         plane_cnt  = 1;
         width      = 8;
         height     = 8;
         orient     = 0;
         cbase      = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [18:0] v);
         case (idx)
            ptpc_pkg::CSR_START:   start_addr = v[15:0];
            ptpc_pkg::CSR_CHARINC: char_inc = v;
            ptpc_pkg::CSR_PLANES:  plane_cnt = v[3:0];
            ptpc_pkg::CSR_WIDTH:   width = v[5:0];
            ptpc_pkg::CSR_HEIGHT:  height = v[5:0];
            ptpc_pkg::CSR_ORIENT:  orient = v[2:0];
            ptpc_pkg::CSR_CBASE:   cbase = v[7:0];
            default: ;
         endcase
      endfunction

      function int planes();
         return (plane_cnt > 8) ? 8 : int'(plane_cnt);
      endfunction

      // bit addresses wrap at 2^19, so keep only the low bits
      function logic [18:0] plane_bit(request_type q, int p);
         logic [63:0] sum;
         sum = 64'(start_addr) * 8 + 64'(q.sprite) * 64'(char_inc)
               + 64'(xoff[q.sx]) + 64'(yoff[q.sy]) + 64'(poff[p]);
         return sum[18:0];
      endfunction

      // Return a transfer that fills in the first unwritten entry q would read.
      function bit find_gap(request_type q, output request_type fix);
         logic [18:0] a;
         fix = q;
         fix.data = 19'($urandom_range(0, 19'h7FFFF));
         if (q.func == ptpc_pkg::FUNC_RD_ROM && !rom_set[q.address]) begin
            fix.func = ptpc_pkg::FUNC_WR_ROM;
            return 1;
         end
         if (q.func != ptpc_pkg::FUNC_DECODE && q.func != ptpc_pkg::FUNC_ENCODE) return 0;
         fix.func = ptpc_pkg::FUNC_WR_LAY;
         fix.data = 19'($urandom_range(0, 63));
         if (!xset[q.sx]) begin
            fix.tsel = ptpc_pkg::TSEL_X;
            fix.address = 16'(q.sx);
            return 1;
         end
         if (!yset[q.sy]) begin
            fix.tsel = ptpc_pkg::TSEL_Y;
            fix.address = 16'(q.sy);
            return 1;
         end
         for (int p = 0; p < planes(); p++) begin
            if (!pset[p]) begin
               fix.tsel = ptpc_pkg::TSEL_P;
               fix.address = 16'(p);
               return 1;
            end
         end
         for (int p = 0; p < planes(); p++) begin
            a = plane_bit(q, p);
            if (!rom_set[a[18:3]]) begin
               fix.func = ptpc_pkg::FUNC_WR_ROM;
               fix.address = a[18:3];
               fix.data = 19'($urandom_range(0, 19'h7FFFF));
               return 1;
            end
         end
         return 0;
      endfunction

      function void absorb_request(request_type q);
         response_type r;
         logic [4:0]   rx;
         logic [4:0]   ry;
         logic [7:0]   v;
         logic [18:0]  a;
         int           n;
         r = '{default: 0};
         n = planes();
         case (q.func)
            ptpc_pkg::FUNC_WR_ROM: begin
               rom[q.address] = q.data[7:0];
               rom_set[q.address] = 1;
            end
            ptpc_pkg::FUNC_RD_ROM: r.rd = rom[q.address];
            ptpc_pkg::FUNC_WR_LAY: begin
               if (q.tsel == ptpc_pkg::TSEL_X && q.address < 32) begin
                  xoff[q.address] = q.data;
                  xset[q.address] = 1;
               end else if (q.tsel == ptpc_pkg::TSEL_Y && q.address < 32) begin
                  yoff[q.address] = q.data;
                  yset[q.address] = 1;
               end else if (q.tsel == ptpc_pkg::TSEL_P && q.address < 8) begin
                  poff[q.address] = q.data;
                  pset[q.address] = 1;
               end
            end
            ptpc_pkg::FUNC_DECODE, ptpc_pkg::FUNC_ENCODE: begin
               rx = width[4:0] - 5'd1 - q.sx;
               ry = height[4:0] - 5'd1 - q.sy;
               case (orient)
                  ptpc_pkg::ORI_FLIPX:  begin r.dx = rx;   r.dy = q.sy; end
                  ptpc_pkg::ORI_FLIPY:  begin r.dx = q.sx; r.dy = ry;   end
                  ptpc_pkg::ORI_ROT180: begin r.dx = rx;   r.dy = ry;   end
                  ptpc_pkg::ORI_ROT90:  begin r.dx = ry;   r.dy = q.sx; end
                  ptpc_pkg::ORI_ROT270: begin r.dx = q.sy; r.dy = rx;   end
                  default:              begin r.dx = q.sx; r.dy = q.sy; end
               endcase
               v = (q.func == ptpc_pkg::FUNC_DECODE) ? 8'd0 : q.pixel - cbase;
               for (int p = 0; p < n; p++) begin
                  a = plane_bit(q, p);
                  if (q.func == ptpc_pkg::FUNC_DECODE) v[n - 1 - p] = rom[a[18:3]][7 - a[2:0]];
                  else rom[a[18:3]][7 - a[2:0]] = v[n - 1 - p];
               end
               if (q.func == ptpc_pkg::FUNC_DECODE) r.color = cbase + v;
            end
            default: ;
         endcase
         pending.push_back(r);
      endfunction

      function void check_response(response_type got);
         response_type w;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected transfer rd=%h color=%h dx=%0d dy=%0d",
                                           got.rd, got.color, got.dx, got.dy);
            return;
         end
         w = pending.pop_front();
         checked++;
         if (got != w) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch #%0d: rd %h/%h color %h/%h dx %0d/%0d dy %0d/%0d (exp/act)",
                        checked, w.rd, got.rd, w.color, got.color, w.dx, got.dx, w.dy, got.dy);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [18:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func = '0;
   logic [15:0] req_address = '0;
   logic [1:0]  req_table_select = '0;
   logic [18:0] req_data = '0;
   logic [11:0] req_sprite_index = '0;
   logic [4:0]  req_src_x = '0;
   logic [4:0]  req_src_y = '0;
   logic [7:0]  req_pixel_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_read_data;
   logic [7:0]  rsp_color;
   logic [4:0]  rsp_dest_x;
   logic [4:0]  rsp_dest_y;

   pixel_codec_tracker tracker = new();
   bit calm = 0;
   int cycles = 0;
   int sent = 0;

   planar_tile_pixel_codec u_top (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[planar_tile_pixel_codec] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_response('{rsp_read_data, rsp_color, rsp_dest_x, rsp_dest_y});
      rsp_stall <= !calm && ($urandom_range(0, 99) < 8);
   end

   task automatic set_reg(logic [2:0] idx, logic [18:0] v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      tracker.set_reg(idx, v);
   endtask

   task automatic send(request_type q);
      req_valid <= 1'b1;
      req_func <= q.func;
      req_address <= q.address;
      req_table_select <= q.tsel;
      req_data <= q.data;
      req_sprite_index <= q.sprite;
      req_src_x <= q.sx;
      req_src_y <= q.sy;
      req_pixel_value <= q.pixel;
      do @(posedge clock); while (req_stall);
      tracker.absorb_request(q);
      sent++;
      if (!calm && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // fill in whatever the transfer would read before it is ever read
   task automatic issue(request_type q);
      request_type fix;
      while (tracker.find_gap(q, fix)) send(fix);
      send(q);
   endtask

   function automatic request_type mk(logic [2:0] f, logic [15:0] a, logic [1:0] t,
                                      logic [18:0] d);
      request_type q;
      q.func = f;
      q.address = a;
      q.tsel = t;
      q.data = d;
      q.sprite = 12'($urandom_range(0, 3));
      q.sx = 5'($urandom);
      q.sy = 5'($urandom);
      q.pixel = 8'($urandom);
      return q;
   endfunction

   function automatic request_type random_request();
      request_type q;
      int r;
      r = $urandom_range(0, 99);
      q = mk(ptpc_pkg::FUNC_DECODE, 16'($urandom), 2'($urandom_range(0, 3)),
             19'($urandom_range(0, 19'h7FFFF)));
      if ($urandom_range(0, 7) == 0) q.sprite = 12'($urandom);
      if (r < 10) begin
         q.func = ptpc_pkg::FUNC_WR_LAY;
         if ($urandom_range(0, 3) != 0) q.address = 16'($urandom_range(0, 33));
         if ($urandom_range(0, 7) != 0) q.data = 19'($urandom_range(0, 63));
      end else if (r < 25) begin
         q.func = ptpc_pkg::FUNC_WR_ROM;
         if ($urandom_range(0, 1) != 0)
            q.address = tracker.start_addr + 16'($urandom_range(0, 63));
      end else if (r < 35) begin
         q.func = ptpc_pkg::FUNC_RD_ROM;
      end else if (r < 39) begin
         q.func = ptpc_pkg::FUNC_ENCODE + 3'($urandom_range(1, 3));
      end else if (r < 70) begin
         q.func = ptpc_pkg::FUNC_DECODE;
      end else begin
         q.func = ptpc_pkg::FUNC_ENCODE;
      end
      return q;
   endfunction

   initial begin
      request_type q;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         // hold off until the codec has drained
         req_valid <= 1'b0;
         while (tracker.pending.size() != 0) @(posedge clock);
         repeat (30) @(posedge clock);
         case (ph)
            0: begin
               set_reg(ptpc_pkg::CSR_START, 0);        set_reg(ptpc_pkg::CSR_CHARINC, 64);
               set_reg(ptpc_pkg::CSR_PLANES, 4);       set_reg(ptpc_pkg::CSR_WIDTH, 8);
               set_reg(ptpc_pkg::CSR_HEIGHT, 8);       set_reg(ptpc_pkg::CSR_ORIENT, 0);
               set_reg(ptpc_pkg::CSR_CBASE, 8'h10);
            end
            1: begin
               set_reg(ptpc_pkg::CSR_START, 16'hFFFF); set_reg(ptpc_pkg::CSR_CHARINC, 19'h7FFFF);
               set_reg(ptpc_pkg::CSR_PLANES, 8);       set_reg(ptpc_pkg::CSR_WIDTH, 32);
               set_reg(ptpc_pkg::CSR_HEIGHT, 32);
               set_reg(ptpc_pkg::CSR_ORIENT, ptpc_pkg::ORI_ROT270);
               set_reg(ptpc_pkg::CSR_CBASE, 8'hFF);
            end
            2: begin
               set_reg(ptpc_pkg::CSR_START, 0);        set_reg(ptpc_pkg::CSR_CHARINC, 0);
               set_reg(ptpc_pkg::CSR_PLANES, 15);      set_reg(ptpc_pkg::CSR_WIDTH, 1);
               set_reg(ptpc_pkg::CSR_HEIGHT, 1);       set_reg(ptpc_pkg::CSR_ORIENT, 7);
               set_reg(ptpc_pkg::CSR_CBASE, 0);
            end
            3: begin
               set_reg(ptpc_pkg::CSR_PLANES, 0);       set_reg(ptpc_pkg::CSR_WIDTH, 63);
               set_reg(ptpc_pkg::CSR_HEIGHT, 0);
               set_reg(ptpc_pkg::CSR_ORIENT, ptpc_pkg::ORI_ROT90);
            end
            default: begin
               set_reg(ptpc_pkg::CSR_START, 19'($urandom_range(0, 16'hFFFF)));
               set_reg(ptpc_pkg::CSR_CHARINC, 19'($urandom_range(0, 19'h7FFFF)));
               set_reg(ptpc_pkg::CSR_PLANES, 19'($urandom_range(1, 8)));
               set_reg(ptpc_pkg::CSR_WIDTH, 19'($urandom_range(1, 32)));
               set_reg(ptpc_pkg::CSR_HEIGHT, 19'($urandom_range(1, 32)));
               set_reg(ptpc_pkg::CSR_ORIENT, 19'($urandom_range(0, 7)));
               set_reg(ptpc_pkg::CSR_CBASE, 19'($urandom_range(0, 255)));
            end
         endcase
         csr_write_enable <= 1'b0;
         if (ph == 0) begin
            issue(mk(ptpc_pkg::FUNC_WR_ROM, 16'h0000, 0, 19'h7FFFF));
            issue(mk(ptpc_pkg::FUNC_WR_ROM, 16'hFFFF, 0, 19'h00055));
            issue(mk(ptpc_pkg::FUNC_RD_ROM, 16'h0000, 0, 0));
            issue(mk(ptpc_pkg::FUNC_RD_ROM, 16'hFFFF, 0, 0));
            issue(mk(ptpc_pkg::FUNC_WR_LAY, 0, ptpc_pkg::TSEL_X, 0));
            issue(mk(ptpc_pkg::FUNC_WR_LAY, 31, ptpc_pkg::TSEL_X, 19'h7FFFF));
            issue(mk(ptpc_pkg::FUNC_WR_LAY, 0, ptpc_pkg::TSEL_Y, 0));
            issue(mk(ptpc_pkg::FUNC_WR_LAY, 7, ptpc_pkg::TSEL_P, 8));
            // out-of-range layout writes are dropped
            issue(mk(ptpc_pkg::FUNC_WR_LAY, 32, ptpc_pkg::TSEL_X, 5));
            issue(mk(ptpc_pkg::FUNC_WR_LAY, 8, ptpc_pkg::TSEL_P, 5));
            issue(mk(ptpc_pkg::FUNC_WR_LAY, 0, 2'd3, 5));
            issue(mk(ptpc_pkg::FUNC_ENCODE + 3'd1, 16'hFFFF, 2'd3, 19'h7FFFF));
            issue(mk(ptpc_pkg::FUNC_ENCODE + 3'd3, 0, 0, 0));
            q = mk(ptpc_pkg::FUNC_ENCODE, 0, 0, 0);
            q.sx = 0; q.sy = 0; q.pixel = 8'hFF;
            issue(q);
            q.func = ptpc_pkg::FUNC_DECODE;
            issue(q);
            q = mk(ptpc_pkg::FUNC_ENCODE, 0, 0, 0);
            q.sx = 31; q.sy = 31; q.pixel = 0; q.sprite = 12'hFFF;
            issue(q);
            q.func = ptpc_pkg::FUNC_DECODE;
            issue(q);
         end
         while (sent < (ph + 1) * PHASE_ITEMS) begin
            calm = (ph == 4 && sent < 4 * PHASE_ITEMS + 200);
            issue(random_request());
         end
         calm = 0;
      end
      req_valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d transfers over %0d register settings; %0d results checked.",
               sent, PHASES, tracker.checked);
      if (tracker.mismatches == 0)
         $display("[planar_tile_pixel_codec] OK");
      else
         $display("[planar_tile_pixel_codec] ERROR");
      $finish;
   end

endmodule
